// ----- rtl/qsr_pkg.sv -----
// Package for the quadratic root solver: result status codes.
package qsr_pkg;

  // Status reported with every result
  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_NEG_DISC = 2'd1,
    STAT_A_ZERO   = 2'd2,
    STAT_SAT      = 2'd3
  } status_e;

endpackage

// ----- rtl/quadratic_smallest_positive_root.sv -----
// Pipelined quadratic solver for ray tests; for positive a it returns the smallest positive root.
//
// Usage: each request on the slave stream carries a, b, c (signed fixed point,
// FRAC_BITS fraction bits) packed in s_axis_tdata_i. The block forms
// D = b*b - 4ac exactly, takes floor(sqrt(D)) one result bit per stage, and
// divides both numerators -b -/+ sqrt(D) (shifted by FRAC_BITS) by 2a with two
// restoring dividers, one quotient bit per stage. t1 is returned when it is
// strictly positive, else t2. The result leaves on the master stream: root in
// m_axis_tdata_o, used_larger_root and status in m_axis_tuser_o.
// Stages from acceptance to tvalid: input register, multiply, discriminant,
// DATA_WIDTH+2 square-root stages, numerator stage, DATA_WIDTH+3+FRAC_BITS
// divider stages and the output register.
// Throughput: one request per cycle while the master side takes results; the
// square root and divider stages hold one request each.
// Reset clears every valid bit; the pipeline comes up empty and ready.
// Stall: while a result waits on the master side with tready low, the whole
// pipeline holds and s_axis_tready_o drops; nothing is lost or repeated.
// Bubbles inside the pipeline travel as cleared valid bits.
module quadratic_smallest_positive_root #(
  parameter int FRAC_BITS  = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic s_axis_tvalid_i,
  output logic s_axis_tready_o,
  // [W-1:0] coef_a, [2W-1:W] coef_b, [3W-1:2W] coef_c, zero padding above
  input  logic [((3*DATA_WIDTH+7)/8)*8-1:0] s_axis_tdata_i,
  output logic m_axis_tvalid_o,
  input  logic m_axis_tready_i,
  // [W-1:0] root, zero padding above
  output logic [((DATA_WIDTH+7)/8)*8-1:0] m_axis_tdata_o,
  // [0] used_larger_root, [2:1] status
  output logic [2:0] m_axis_tuser_o
);

  localparam int W    = DATA_WIDTH;
  localparam int F    = FRAC_BITS;
  localparam int OUTW = ((DATA_WIDTH+7)/8)*8;
  localparam int DW   = 2*W+4;     // discriminant width
  localparam int SW   = W+2;       // square root width
  localparam int RW   = SW+2;      // square root remainder width
  localparam int NSW  = W+4;       // signed numerator width
  localparam int NMW  = W+3;       // numerator magnitude width
  localparam int NW   = NMW+F;     // dividend and quotient width
  localparam int DVW  = W+1;       // divisor width
  localparam int SQ0  = 3;         // first square root stage
  localparam int NUMS = SQ0+SW;    // numerator stage
  localparam int DV0  = NUMS+1;    // first divider stage
  localparam int NST  = DV0+NW;    // stages before the output register

  typedef struct packed {
    logic         aneg;
    logic [W-1:0] amag;
    logic [W-1:0] b;
    logic         azero;
    logic         ndisc;
  } sb_t;

  logic en;
  logic v_q [NST];
  sb_t  sb_q [1:NST-1];

  // whole pipeline advances unless a result is held at the output
  assign en = !m_axis_tvalid_o || m_axis_tready_i;
  assign s_axis_tready_o = en;

  // input register
  logic [W-1:0] a0_q, b0_q, c0_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q[0] <= 1'b0;
    end else if (en) begin
      v_q[0] <= s_axis_tvalid_i;
    end
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      a0_q <= s_axis_tdata_i[W-1:0];
      b0_q <= s_axis_tdata_i[2*W-1:W];
      c0_q <= s_axis_tdata_i[3*W-1:2*W];
    end
  end

  // stage 1: magnitudes and products
  logic [W-1:0]   am, bm, cm;
  logic [2*W-1:0] b2_q, ac_q;
  logic           sum_q;
  assign am = a0_q[W-1] ? (~a0_q + 1'b1) : a0_q;
  assign bm = b0_q[W-1] ? (~b0_q + 1'b1) : b0_q;
  assign cm = c0_q[W-1] ? (~c0_q + 1'b1) : c0_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q[1] <= 1'b0;
    end else if (en) begin
      v_q[1] <= v_q[0];
    end
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      b2_q        <= bm * bm;
      ac_q        <= am * cm;
      sum_q       <= (a0_q[W-1] != c0_q[W-1]) && (cm != '0);
      sb_q[1].aneg  <= a0_q[W-1];
      sb_q[1].amag  <= am;
      sb_q[1].b     <= b0_q;
      sb_q[1].azero <= (am == '0);
      sb_q[1].ndisc <= 1'b0;
    end
  end

  // stage 2: discriminant
  logic [DW-1:0] b2x, ac4x;
  logic [DW-1:0] sx_q [SW+1];
  logic [RW-1:0] rm_q [SW+1];
  logic [SW-1:0] sr_q [SW+1];
  assign b2x  = {4'b0, b2_q};
  assign ac4x = {2'b0, ac_q, 2'b0};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q[2] <= 1'b0;
    end else if (en) begin
      v_q[2] <= v_q[1];
    end
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      sx_q[0]       <= sum_q ? (b2x + ac4x) : (b2x - ac4x);
      rm_q[0]       <= '0;
      sr_q[0]       <= '0;
      sb_q[2].aneg  <= sb_q[1].aneg;
      sb_q[2].amag  <= sb_q[1].amag;
      sb_q[2].b     <= sb_q[1].b;
      sb_q[2].azero <= sb_q[1].azero;
      sb_q[2].ndisc <= !sum_q && (b2x < ac4x);
    end
  end

  // square root: one result bit per stage
  for (genvar i = 0; i < SW; i++) begin : g_sqrt
    logic [RW-1:0] remn, trial;
    logic          ge;
    assign remn  = {rm_q[i][RW-3:0], sx_q[i][DW-1:DW-2]};
    assign trial = {sr_q[i], 2'b01};
    assign ge    = remn >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[SQ0+i] <= 1'b0;
      end else if (en) begin
        v_q[SQ0+i] <= v_q[SQ0+i-1];
      end
    end
    always_ff @(posedge clk_i) begin
      if (en) begin
        sx_q[i+1]    <= {sx_q[i][DW-3:0], 2'b00};
        rm_q[i+1]    <= ge ? (remn - trial) : remn;
        sr_q[i+1]    <= {sr_q[i][SW-2:0], ge};
        sb_q[SQ0+i]  <= sb_q[SQ0+i-1];
      end
    end
  end

  // numerator stage: -b - s and -b + s, signs and dividends
  logic signed [NSW-1:0] bs, ss, n1, n2;
  logic [NSW-1:0]        m1, m2;
  logic [NW-1:0]         dq1_q [NW+1];
  logic [NW-1:0]         dq2_q [NW+1];
  logic [DVW-1:0]        dr1_q [NW+1];
  logic [DVW-1:0]        dr2_q [NW+1];
  logic                  ng1_q [NW+1];
  logic                  ng2_q [NW+1];
  sb_t                   sbn;
  assign sbn = sb_q[NUMS-1];
  assign bs  = signed'({{(NSW-W){sbn.b[W-1]}}, sbn.b});
  assign ss  = signed'({{(NSW-SW){1'b0}}, sr_q[SW]});
  assign n1  = -bs - ss;
  assign n2  = -bs + ss;
  assign m1  = n1[NSW-1] ? -n1 : n1;
  assign m2  = n2[NSW-1] ? -n2 : n2;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q[NUMS] <= 1'b0;
    end else if (en) begin
      v_q[NUMS] <= v_q[NUMS-1];
    end
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      dq1_q[0]   <= {m1[NMW-1:0], {F{1'b0}}};
      dq2_q[0]   <= {m2[NMW-1:0], {F{1'b0}}};
      dr1_q[0]   <= '0;
      dr2_q[0]   <= '0;
      ng1_q[0]   <= n1[NSW-1] != sbn.aneg;
      ng2_q[0]   <= n2[NSW-1] != sbn.aneg;
      sb_q[NUMS] <= sbn;
    end
  end

  // two restoring dividers by 2a, one quotient bit per stage
  for (genvar i = 0; i < NW; i++) begin : g_div
    logic [DVW-1:0] dv, r1, r2;
    logic           ge1, ge2;
    assign dv  = {sb_q[DV0+i-1].amag, 1'b0};
    assign r1  = {dr1_q[i][DVW-2:0], dq1_q[i][NW-1]};
    assign r2  = {dr2_q[i][DVW-2:0], dq2_q[i][NW-1]};
    assign ge1 = r1 >= dv;
    assign ge2 = r2 >= dv;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[DV0+i] <= 1'b0;
      end else if (en) begin
        v_q[DV0+i] <= v_q[DV0+i-1];
      end
    end
    always_ff @(posedge clk_i) begin
      if (en) begin
        dq1_q[i+1]  <= {dq1_q[i][NW-2:0], ge1};
        dq2_q[i+1]  <= {dq2_q[i][NW-2:0], ge2};
        dr1_q[i+1]  <= ge1 ? (r1 - dv) : r1;
        dr2_q[i+1]  <= ge2 ? (r2 - dv) : r2;
        ng1_q[i+1]  <= ng1_q[i];
        ng2_q[i+1]  <= ng2_q[i];
        sb_q[DV0+i] <= sb_q[DV0+i-1];
      end
    end
  end

  // saturation, root choice and status
  logic [NW-1:0] lim1, lim2;
  logic          sat1, sat2, pos1;
  logic [W-1:0]  mg1, mg2, t1, t2;
  sb_t           sbl;
  assign sbl  = sb_q[NST-1];
  assign lim1 = ng1_q[NW] ? (NW'(1) << (W-1)) : ((NW'(1) << (W-1)) - 1'b1);
  assign lim2 = ng2_q[NW] ? (NW'(1) << (W-1)) : ((NW'(1) << (W-1)) - 1'b1);
  assign sat1 = dq1_q[NW] > lim1;
  assign sat2 = dq2_q[NW] > lim2;
  assign mg1  = sat1 ? lim1[W-1:0] : dq1_q[NW][W-1:0];
  assign mg2  = sat2 ? lim2[W-1:0] : dq2_q[NW][W-1:0];
  assign t1   = ng1_q[NW] ? (~mg1 + 1'b1) : mg1;
  assign t2   = ng2_q[NW] ? (~mg2 + 1'b1) : mg2;
  assign pos1 = !ng1_q[NW] && (dq1_q[NW] != '0);

  logic [W-1:0]     root_d, root_q;
  logic             lg_d, lg_q;
  qsr_pkg::status_e st_d, st_q;
  logic             ov_q;

  always_comb begin
    root_d = pos1 ? t1 : t2;
    lg_d   = !pos1;
    st_d   = (pos1 ? sat1 : sat2) ? qsr_pkg::STAT_SAT : qsr_pkg::STAT_OK;
    if (sbl.azero) begin
      root_d = '0;
      lg_d   = 1'b0;
      st_d   = qsr_pkg::STAT_A_ZERO;
    end else if (sbl.ndisc) begin
      root_d = '0;
      lg_d   = 1'b0;
      st_d   = qsr_pkg::STAT_NEG_DISC;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (en) begin
      ov_q <= v_q[NST-1];
    end
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      root_q <= root_d;
      lg_q   <= lg_d;
      st_q   <= st_d;
    end
  end

  assign m_axis_tvalid_o = ov_q;
  assign m_axis_tdata_o  = OUTW'(root_q);
  assign m_axis_tuser_o  = {st_q, lg_q};

endmodule
